@@ hw/rtl/iwdt_pkg.sv @@
package iwdt_pkg;
    localparam int NET_COUNT     = 65536;
    localparam int NET_BITS      = $clog2(NET_COUNT);
    localparam int PENDING_DEPTH = 256;
    localparam int PEND_BITS     = $clog2(PENDING_DEPTH);
    localparam int STAMP_BITS    = 16;
    localparam int WL_BITS       = 32;
    localparam int SUM_BITS      = 48;
    localparam int RES_BITS      = 49;
    localparam int Q_DEPTH       = 4;
    localparam int Q_BITS        = $clog2(Q_DEPTH);

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    typedef enum logic [2:0] {
        CMD_FULL   = 3'd0,
        CMD_TRIAL  = 3'd1,
        CMD_BUILD  = 3'd2,
        CMD_CACHED = 3'd3,
        CMD_COMMIT = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] edge_id;
        logic [15:0] pin_count;
        logic [31:0] wirelength;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic signed [48:0] result_value;
        logic [15:0]        overlap_count;
        logic               list_overflow;
    } t_out_item;

    // classified operation handed from front to back
    typedef struct packed {
        logic [2:0]          cmd;
        logic                use_net;
        logic [NET_BITS-1:0] net;
        logic [WL_BITS-1:0]  wl;
        logic                last;
    } t_op;
endpackage

@@ hw/rtl/iwdt_ram.sv @@
module iwdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hw/rtl/iwdt_front.sv @@
module iwdt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  iwdt_pkg::t_in_item i_item,
    input  logic [15:0]     i_thresh,
    output logic            o_q_valid,
    output iwdt_pkg::t_op   o_q_op,
    input  logic            i_q_pop
);
    import iwdt_pkg::*;

    t_op              r_q [Q_DEPTH];
    logic [Q_BITS-1:0] r_wp, r_rp;
    logic [Q_BITS:0]   r_cnt;
    logic push;
    t_op  op;

    always_comb begin
        op.cmd     = i_item.cmd;
        op.use_net = (i_item.pin_count >= 16'd2) && (i_item.pin_count < i_thresh)
                     && ({16'd0, i_item.edge_id} < 32'(NET_COUNT));
        op.net     = i_item.edge_id[NET_BITS-1:0];
        op.wl      = i_item.wirelength[WL_BITS-1:0];
        op.last    = i_item.last;
    end

    assign o_stall   = (r_cnt == (Q_BITS+1)'(Q_DEPTH));
    // unused commands are dropped here
    assign push      = i_valid && !o_stall && (i_item.cmd <= CMD_COMMIT);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_op    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= op;
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_BITS+1)'(push) - (Q_BITS+1)'(i_q_pop);
        end
    end
endmodule

@@ hw/rtl/iwdt_back.sv @@
module iwdt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  iwdt_pkg::t_op   i_q_op,
    output logic            o_q_pop,
    output logic            o_clearing,
    output logic            o_valid,
    input  logic            i_stall,
    output iwdt_pkg::t_out_item o_item
);
    import iwdt_pkg::*;

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_COMMIT_RD,
                              ST_COMMIT_WR, ST_WIPE} t_state;

    t_state r_state;
    t_op    r_op;
    logic [NET_BITS:0]   r_wipe;
    logic [STAMP_BITS-1:0] r_epoch;
    logic [PEND_BITS:0]  r_pcount, r_k;
    logic                r_pover, r_pass_open, r_valid;
    logic [SUM_BITS-1:0] r_sum_old, r_sum_new;
    logic signed [RES_BITS-1:0] r_base;
    logic [15:0]         r_ovl;
    t_out_item           r_out;

    // committed: {valid, wl}; valid clears in the reset clearing pass so reset reads zero
    logic                c_we, s_we, k_we, p_we;
    logic [NET_BITS-1:0] c_wa, s_wa, c_ra;
    logic [WL_BITS:0]    c_wd, c_rd;
    logic [STAMP_BITS-1:0] s_wd, s_rd;
    logic [WL_BITS-1:0]  k_rd;
    logic [NET_BITS+WL_BITS-1:0] p_rd;
    logic [PEND_BITS-1:0] p_ra, p_wa;

    iwdt_ram #(.WIDTH(WL_BITS+1), .DEPTH(NET_COUNT)) u_comm (.i_clk, .i_we(c_we),
        .i_waddr(c_wa), .i_wdata(c_wd), .i_raddr(c_ra), .o_rdata(c_rd));
    iwdt_ram #(.WIDTH(STAMP_BITS), .DEPTH(NET_COUNT)) u_stamp (.i_clk, .i_we(s_we),
        .i_waddr(s_wa), .i_wdata(s_wd), .i_raddr(c_ra), .o_rdata(s_rd));
    iwdt_ram #(.WIDTH(WL_BITS), .DEPTH(NET_COUNT)) u_cache (.i_clk, .i_we(k_we),
        .i_waddr(r_op.net), .i_wdata(r_op.wl), .i_raddr(c_ra), .o_rdata(k_rd));
    iwdt_ram #(.WIDTH(NET_BITS+WL_BITS), .DEPTH(PENDING_DEPTH)) u_pend (.i_clk,
        .i_we(p_we), .i_waddr(p_wa), .i_wdata({r_op.net, r_op.wl}),
        .i_raddr(p_ra), .o_rdata(p_rd));

    function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] a,
                                                    logic [WL_BITS-1:0] b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + (SUM_BITS+1)'(b);
        return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
    endfunction

    // pass-start view of the accumulators
    logic                first;
    logic [SUM_BITS-1:0] so, sn, nso, nsn;
    logic [15:0]         ov, nov;
    logic [STAMP_BITS-1:0] ep, ep_inc;
    logic                wrap, pov;
    logic [PEND_BITS:0]  pc;
    logic [WL_BITS-1:0]  old_wl;
    logic                hit;
    logic signed [RES_BITS+1:0] d, tot;
    logic signed [RES_BITS-1:0] val;

    assign ep_inc = r_epoch + 1'b1;
    always_comb begin
        first = !r_pass_open;
        so  = first ? '0 : r_sum_old;
        sn  = first ? '0 : r_sum_new;
        ov  = first ? '0 : r_ovl;
        ep  = r_epoch;
        wrap = 1'b0;
        pc  = r_pcount;
        pov = r_pover;
        if (first && r_op.cmd == CMD_TRIAL) begin
            pc = '0; pov = 1'b0;
        end
        if (first && r_op.cmd == CMD_BUILD) begin
            wrap = (ep_inc == '0);
            ep   = wrap ? STAMP_BITS'(1) : ep_inc;
        end
        old_wl = c_rd[WL_BITS] ? c_rd[WL_BITS-1:0] : '0;
        hit = (s_rd == ep) && !wrap;
        nso = so; nsn = sn; nov = ov;
        if (r_op.use_net) begin
            case (r_op.cmd)
                CMD_FULL: nso = sat_add(so, r_op.wl);
                CMD_TRIAL, CMD_BUILD: begin
                    nso = sat_add(so, old_wl); nsn = sat_add(sn, r_op.wl);
                end
                default: begin
                    nso = sat_add(so, hit ? k_rd : old_wl);
                    nsn = sat_add(sn, r_op.wl);
                    if (hit && ov != 16'hffff) nov = ov + 1'b1;
                end
            endcase
        end
        d = $signed({3'b0, nso}) - $signed({3'b0, nsn});
        tot = d + (RES_BITS+2)'(r_base);
        if (tot > $signed((RES_BITS+2)'(SUM_MAX))) val = RES_BITS'(SUM_MAX);
        else if (tot < -$signed((RES_BITS+2)'(SUM_MAX))) val = -RES_BITS'(SUM_MAX);
        else val = tot[RES_BITS-1:0];
    end

    logic exec;
    assign exec = (r_state == ST_EXEC);
    logic trial_fit;
    assign trial_fit = (pc < (PEND_BITS+1)'(PENDING_DEPTH));

    always_comb begin
        c_we = 1'b0; c_wa = r_op.net; c_wd = {1'b1, r_op.wl};
        s_we = 1'b0; s_wa = r_op.net; s_wd = ep;
        k_we = 1'b0; p_we = 1'b0;
        // tables are read in the read state so exec sees the held item's entries
        c_ra = r_op.net;
        p_ra = r_k[PEND_BITS-1:0];
        p_wa = pc[PEND_BITS-1:0];
        if (r_state == ST_CLEAR || r_state == ST_WIPE) begin
            s_we = 1'b1; s_wa = r_wipe[NET_BITS-1:0]; s_wd = '0;
            c_we = (r_state == ST_CLEAR); c_wa = r_wipe[NET_BITS-1:0]; c_wd = '0;
        end else if (r_state == ST_COMMIT_WR) begin
            c_we = 1'b1; c_wa = p_rd[NET_BITS+WL_BITS-1:WL_BITS];
            c_wd = {1'b1, p_rd[WL_BITS-1:0]};
        end else if (exec && r_op.use_net && !wrap) begin
            c_we = (r_op.cmd == CMD_FULL);
            s_we = (r_op.cmd == CMD_BUILD);
            k_we = (r_op.cmd == CMD_BUILD);
            p_we = (r_op.cmd == CMD_TRIAL) && trial_fit;
        end
    end

    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid && !(r_valid && i_stall);
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_valid    = r_valid;
    assign o_item     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_wipe <= '0; r_epoch <= STAMP_BITS'(1);
            r_pcount <= '0; r_pover <= 1'b0; r_pass_open <= 1'b0; r_valid <= 1'b0;
            r_sum_old <= '0; r_sum_new <= '0; r_base <= '0; r_ovl <= '0; r_k <= '0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            unique case (r_state)
                ST_CLEAR, ST_WIPE: begin
                    if (r_wipe[NET_BITS-1:0] == '1) begin
                        r_wipe <= '0;
                        // a build item that wrapped the epoch is run again after the wipe
                        r_state <= (r_state == ST_WIPE && r_op.cmd == CMD_BUILD) ?
                                   ST_READ : ST_IDLE;
                    end else r_wipe <= r_wipe + 1'b1;
                end
                ST_IDLE: if (o_q_pop) begin
                    r_op <= i_q_op;
                    r_state <= (i_q_op.cmd == CMD_COMMIT) ? ST_COMMIT_RD : ST_READ;
                    r_k <= '0;
                end
                ST_READ: r_state <= ST_EXEC;
                ST_EXEC: begin
                    if (wrap) begin
                        // clear the stamps first, the rerun then steps the epoch to one
                        r_epoch <= '0;
                        r_state <= ST_WIPE;
                    end else begin
                        r_epoch <= ep;
                        r_pcount <= (r_op.use_net && r_op.cmd == CMD_TRIAL && trial_fit) ?
                                    pc + 1'b1 : pc;
                        r_pover <= (r_op.use_net && r_op.cmd == CMD_TRIAL && !trial_fit) ?
                                   1'b1 : pov;
                        r_sum_old <= nso; r_sum_new <= nsn; r_ovl <= nov;
                        r_pass_open <= !r_op.last;
                        if (r_op.last) begin
                            r_valid <= 1'b1;
                            r_out.overlap_count <= (r_op.cmd == CMD_CACHED) ? nov : '0;
                            r_out.list_overflow <= (r_op.use_net && r_op.cmd == CMD_TRIAL
                                                    && !trial_fit) ? 1'b1 : pov;
                            case (r_op.cmd)
                                CMD_FULL: r_out.result_value <= $signed({1'b0, nso});
                                CMD_TRIAL: r_out.result_value <= d[RES_BITS-1:0];
                                CMD_BUILD: begin
                                    r_out.result_value <= d[RES_BITS-1:0];
                                    r_base <= d[RES_BITS-1:0];
                                end
                                default: r_out.result_value <= val;
                            endcase
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_COMMIT_RD: begin
                    if (r_k >= r_pcount) begin
                        r_pcount <= '0; r_pover <= 1'b0; r_pass_open <= 1'b0;
                        r_sum_old <= '0; r_sum_new <= '0; r_ovl <= '0;
                        r_epoch <= (ep_inc == '0) ? STAMP_BITS'(1) : ep_inc;
                        r_state <= (ep_inc == '0) ? ST_WIPE : ST_IDLE;
                    end else r_state <= ST_COMMIT_WR;
                end
                ST_COMMIT_WR: begin
                    r_k <= r_k + 1'b1; r_state <= ST_COMMIT_RD;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/incremental_wirelength_delta_table_core.sv @@
// channel  | handshake          | payload
// in       | i_valid / o_stall  | i_item (t_in_item)
// out      | o_valid / i_stall  | o_item (t_out_item)
// cfg      | i_cfg_valid / o_cfg_ready | i_cfg_data (threshold)
// a net item passes the back part's read and exec states (table read, update);
// the front queue holds 4 transactions. commit reads, then writes each recorded
// entry. after reset a clearing pass over all 65536 entries runs before items
// are taken; an epoch wrap wipes all stamps. output stall backs up the queue.
module incremental_wirelength_delta_table_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  iwdt_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output iwdt_pkg::t_out_item o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    import iwdt_pkg::*;

    logic [15:0] r_thresh;
    logic q_valid, q_pop, clearing, f_stall;
    t_op  q_op;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thresh <= 16'd100;
        else if (i_cfg_valid) r_thresh <= i_cfg_data;
    end

    assign o_stall = f_stall || clearing;

    iwdt_front u_front (.i_clk, .i_rst_n, .i_valid(i_valid && !clearing),
        .o_stall(f_stall), .i_item, .i_thresh(r_thresh), .o_q_valid(q_valid),
        .o_q_op(q_op), .i_q_pop(q_pop));

    iwdt_back u_back (.i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_op(q_op),
        .o_q_pop(q_pop), .o_clearing(clearing), .o_valid, .i_stall, .o_item);
endmodule

@@ hw/rtl/iwdt_checker.sv @@
module iwdt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input iwdt_pkg::t_out_item o_item
);
    import iwdt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item)) else $error("out held");
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall) else $error("stall after reset");
    a_rst_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({i_valid, o_stall, o_valid}) && (!o_valid || !$isunknown(o_item)))
        else $error("unknown handshake or result");
endmodule

bind incremental_wirelength_delta_table_core iwdt_checker u_chk (.i_clk, .i_rst_n,
    .i_valid, .o_stall, .o_valid, .i_stall, .o_item);

@@ sim/tb_incremental_wirelength_delta_table_core.sv @@
`timescale 1ns / 100ps

module tb_incremental_wirelength_delta_table_core;
    import iwdt_pkg::*;

    localparam int  HALF_PERIOD  = 6;
    localparam int  CYCLE_LIMIT  = 500_000;
    localparam int  SETTLE_CYCLES = 700;
    localparam int  RANDOM_ITEMS = 420;
    localparam int  LONG_TRIAL   = 280;
    localparam int  MAX_PRINTS   = 40;
    localparam logic [2:0] CMD_UNUSED_A = 3'd5;
    localparam logic [2:0] CMD_UNUSED_B = 3'd6;
    localparam logic [2:0] CMD_UNUSED_C = 3'd7;
    localparam longint SUM_LIM = (64'sd1 <<< SUM_BITS) - 1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    incremental_wirelength_delta_table_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------- delta table predictor ----------------
    logic [WL_BITS-1:0]    committed_tab [NET_COUNT];
    logic [WL_BITS-1:0]    cached_tab    [NET_COUNT];
    logic [STAMP_BITS-1:0] stamp_tab     [NET_COUNT];
    logic [15:0]           trial_ids     [PENDING_DEPTH];
    logic [WL_BITS-1:0]    trial_wl      [PENDING_DEPTH];
    logic [STAMP_BITS-1:0] cur_epoch;
    int                    trial_n;
    bit                    trial_dropped;
    longint                old_total, new_total, build_delta;
    int                    stamped_hits;
    bit                    pass_live;
    logic [15:0]           pin_limit;

    t_out_item delta_results [$];
    t_in_item  pending_items [$];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int epoch_wraps = 0;

    function automatic longint sat_sum(longint a, longint b);
        longint r;
        r = a + b;
        return (r > SUM_LIM) ? SUM_LIM : r;
    endfunction

    task automatic advance_epoch();
        cur_epoch = cur_epoch + 1'b1;
        if (cur_epoch == '0) begin
            foreach (stamp_tab[n]) stamp_tab[n] = '0;
            cur_epoch = STAMP_BITS'(1);
            epoch_wraps++;
        end
    endtask

    task automatic predict_delta(input t_in_item it);
        longint    val;
        t_out_item res;
        int        n;
        if (it.cmd > CMD_COMMIT) return;
        if (it.cmd == CMD_COMMIT) begin
            for (int k = 0; k < trial_n; k++) committed_tab[trial_ids[k]] = trial_wl[k];
            trial_n = 0;
            trial_dropped = 0;
            pass_live = 0;
            old_total = 0;
            new_total = 0;
            stamped_hits = 0;
            advance_epoch();
            return;
        end
        if (!pass_live) begin
            pass_live = 1;
            old_total = 0;
            new_total = 0;
            stamped_hits = 0;
            if (it.cmd == CMD_TRIAL) begin
                trial_n = 0;
                trial_dropped = 0;
            end else if (it.cmd == CMD_BUILD) begin
                advance_epoch();
            end
        end
        n = it.edge_id;
        if (it.pin_count >= 2 && it.pin_count < pin_limit) begin
            case (it.cmd)
                CMD_FULL: begin
                    committed_tab[n] = it.wirelength;
                    old_total = sat_sum(old_total, it.wirelength);
                end
                CMD_TRIAL: begin
                    if (trial_n < PENDING_DEPTH) begin
                        trial_ids[trial_n] = it.edge_id;
                        trial_wl[trial_n] = it.wirelength;
                        trial_n++;
                    end else begin
                        trial_dropped = 1;
                    end
                    old_total = sat_sum(old_total, committed_tab[n]);
                    new_total = sat_sum(new_total, it.wirelength);
                end
                CMD_BUILD: begin
                    stamp_tab[n] = cur_epoch;
                    cached_tab[n] = it.wirelength;
                    old_total = sat_sum(old_total, committed_tab[n]);
                    new_total = sat_sum(new_total, it.wirelength);
                end
                default: begin
                    if (stamp_tab[n] == cur_epoch) begin
                        old_total = sat_sum(old_total, cached_tab[n]);
                        if (stamped_hits < 65535) stamped_hits++;
                    end else begin
                        old_total = sat_sum(old_total, committed_tab[n]);
                    end
                    new_total = sat_sum(new_total, it.wirelength);
                end
            endcase
        end
        if (!it.last) return;
        res = '0;
        case (it.cmd)
            CMD_FULL:  val = old_total;
            CMD_TRIAL: val = old_total - new_total;
            CMD_BUILD: begin
                val = old_total - new_total;
                build_delta = val;
            end
            default: begin
                val = build_delta + (old_total - new_total);
                if (val > SUM_LIM) val = SUM_LIM;
                if (val < -SUM_LIM) val = -SUM_LIM;
                res.overlap_count = stamped_hits[15:0];
            end
        endcase
        pass_live = 0;
        res.result_value = val[RES_BITS-1:0];
        res.list_overflow = trial_dropped;
        delta_results.push_back(res);
    endtask

    // ---------------- input driver ----------------
    int burst_left = 1;
    int gap_left = 0;
    int gap_max = 6;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_delta(i_item);
                items_sent++;
            end
            if (i_valid && o_stall) begin
                // held until taken
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items.pop_front();
                i_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------- result monitor ----------------
    int stall_cyc = 0;

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (delta_results.size() == 0) begin
                    report_mismatch("result with none expected", 0, o_item.result_value);
                end else begin
                    want = delta_results.pop_front();
                    if (o_item.result_value !== want.result_value)
                        report_mismatch("result_value", want.result_value, o_item.result_value);
                    if (o_item.overlap_count !== want.overlap_count)
                        report_mismatch("overlap_count", want.overlap_count, o_item.overlap_count);
                    if (o_item.list_overflow !== want.list_overflow)
                        report_mismatch("list_overflow", want.list_overflow,
                                        o_item.list_overflow);
                end
            end
            stall_cyc++;
            case ((stall_cyc / 400) % 4)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                2: i_stall <= ((stall_cyc % 7) < 3);
                default: i_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // ---------------- watchdog ----------------
    int cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", delta_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic add_item(input logic [2:0] cmd, input logic [15:0] id,
                            input logic [15:0] pins, input logic [31:0] wl,
                            input logic last);
        t_in_item it;
        it.cmd = cmd;
        it.edge_id = id;
        it.pin_count = pins;
        it.wirelength = wl;
        it.last = last;
        pending_items.push_back(it);
    endtask

    // no open transaction and nothing outstanding, then let commit / wipe finish
    task automatic drain();
        wait (pending_items.size() == 0 && !i_valid && delta_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pin_limit = val;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_net();
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 23));
        endcase
    endfunction

    function automatic logic [15:0] pick_pins();
        case ($urandom_range(0, 11))
            0: return 16'($urandom_range(0, 1));
            1: return pin_limit;
            2: return 16'($urandom_range(0, 65535));
            default: return (pin_limit > 2) ? 16'($urandom_range(2, pin_limit - 1)) : 16'd2;
        endcase
    endfunction

    function automatic logic [31:0] pick_wl();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    int made;

    task automatic random_passes(input int quota);
        logic [2:0] cmd, c;
        int len;
        while (quota > 0) begin
            case ($urandom_range(0, 15))
                0: begin
                    add_item(CMD_COMMIT, 16'($urandom), 16'($urandom), $urandom,
                             1'($urandom_range(0, 1)));
                    continue;
                end
                1: begin
                    c = 3'($urandom_range(CMD_UNUSED_A, CMD_UNUSED_C));
                    add_item(c, 16'($urandom), 16'($urandom), $urandom,
                             1'($urandom_range(0, 1)));
                    continue;
                end
                2, 3:  cmd = CMD_FULL;
                4, 5, 6: cmd = CMD_TRIAL;
                7, 8, 9: cmd = CMD_BUILD;
                default: cmd = CMD_CACHED;
            endcase
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                // mostly clean passes, a few mixed ones
                c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(CMD_FULL, CMD_CACHED))
                                                 : cmd;
                add_item(c, pick_net(), pick_pins(), pick_wl(), k == len - 1);
            end
            if ($urandom_range(0, 29) == 0)
                add_item(CMD_COMMIT, '0, '0, '0, 1'b0);
            quota -= len;
            made += len;
        end
    endtask

    initial begin
        foreach (committed_tab[n]) begin
            committed_tab[n] = '0;
            cached_tab[n] = '0;
            stamp_tab[n] = '0;
        end
        cur_epoch = STAMP_BITS'(1);
        trial_n = 0;
        trial_dropped = 0;
        old_total = 0;
        new_total = 0;
        build_delta = 0;
        stamped_hits = 0;
        pass_live = 0;
        pin_limit = 16'd100;
        made = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_limit(16'd100);

        // directed
        add_item(CMD_FULL, 16'd0, 16'd2, 32'h0, 1'b0);
        add_item(CMD_FULL, 16'd1, 16'd99, 32'hFFFF_FFFF, 1'b0);
        add_item(CMD_FULL, 16'd2, 16'd1, 32'd5, 1'b0);
        add_item(CMD_FULL, 16'd3, 16'd100, 32'd6, 1'b0);
        add_item(CMD_FULL, 16'hFFFF, 16'd0, 32'd7, 1'b0);
        add_item(CMD_FULL, 16'd4, 16'd50, 32'd1234, 1'b1);
        add_item(CMD_TRIAL, 16'd0, 16'd3, 32'd10, 1'b0);
        add_item(CMD_TRIAL, 16'd1, 16'd3, 32'hFFFF_FFFF, 1'b0);
        add_item(CMD_TRIAL, 16'd9, 16'hFFFF, 32'd3, 1'b1);
        add_item(CMD_COMMIT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        add_item(CMD_BUILD, 16'd0, 16'd2, 32'd7, 1'b0);
        add_item(CMD_BUILD, 16'd5, 16'd2, 32'd8, 1'b1);
        add_item(CMD_CACHED, 16'd0, 16'd2, 32'd3, 1'b0);
        add_item(CMD_CACHED, 16'd6, 16'd2, 32'd4, 1'b0);
        add_item(CMD_CACHED, 16'd0, 16'd2, 32'd1, 1'b1);
        add_item(CMD_TRIAL, 16'd7, 16'd2, 32'd9, 1'b0);
        add_item(CMD_FULL, 16'd8, 16'd2, 32'd11, 1'b0);
        add_item(CMD_CACHED, 16'd5, 16'd2, 32'd2, 1'b1);
        add_item(CMD_UNUSED_A, 16'd1, 16'd2, 32'd1, 1'b1);
        add_item(CMD_UNUSED_B, 16'd1, 16'd2, 32'd1, 1'b0);
        add_item(CMD_UNUSED_C, 16'd1, 16'd2, 32'd1, 1'b1);
        add_item(CMD_FULL, 16'd10, 16'd0, 32'd1, 1'b1);
        add_item(CMD_TRIAL, 16'd11, 16'd2, 32'd5, 1'b0);
        add_item(CMD_COMMIT, 16'd0, 16'd0, 32'd0, 1'b0);
        drain();

        random_passes(RANDOM_ITEMS / 5);
        drain();
        write_limit(16'hFFFF);
        random_passes(RANDOM_ITEMS / 5);
        drain();
        write_limit(16'd2);
        random_passes(RANDOM_ITEMS / 10);
        drain();
        write_limit(16'd3);
        random_passes(RANDOM_ITEMS / 10);
        drain();
        write_limit(16'($urandom_range(4, 65534)));
        random_passes(RANDOM_ITEMS / 5);
        drain();

        // long trial pass: list overflow, then commit it
        write_limit(16'd100);
        gap_max = 0;
        for (int k = 0; k < LONG_TRIAL; k++)
            add_item(CMD_TRIAL, 16'(k), 16'd2, 32'hFFFF_FFFF, k == LONG_TRIAL - 1);
        add_item(CMD_COMMIT, '0, '0, '0, 1'b0);
        drain();

        // build a cache, move the epoch on, then rebuild and hit it
        add_item(CMD_BUILD, 16'd3, 16'd2, 32'd40, 1'b0);
        add_item(CMD_BUILD, 16'd4, 16'd2, 32'd50, 1'b1);
        repeat (3) add_item(CMD_COMMIT, '0, '0, '0, 1'b0);
        add_item(CMD_CACHED, 16'd3, 16'd2, 32'd1, 1'b0);
        add_item(CMD_CACHED, 16'd4, 16'd2, 32'd1, 1'b1);
        add_item(CMD_BUILD, 16'd4, 16'd2, 32'd9, 1'b1);
        add_item(CMD_CACHED, 16'd4, 16'd2, 32'd1, 1'b1);
        drain();

        gap_max = 8;
        write_limit(16'd100);
        random_passes(RANDOM_ITEMS / 5);
        drain();

        $display("%0d items taken, %0d results checked, %0d random net items",
                 items_sent, results_seen, made);
        $display("thresholds 2..65535 exercised, %0d epoch wrap(s), %0d errors",
                 epoch_wraps, errors);
        if (errors == 0 && delta_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

@@ incremental_wirelength_delta_table_core.f @@
hw/rtl/iwdt_pkg.sv
hw/rtl/iwdt_ram.sv
hw/rtl/iwdt_front.sv
hw/rtl/iwdt_back.sv
hw/rtl/incremental_wirelength_delta_table_core.sv
hw/rtl/iwdt_checker.sv
sim/tb_incremental_wirelength_delta_table_core.sv
